/* src/afed_pkg.sv */
package afed_pkg;

   // Default storage depths.
   localparam int WIN_DEPTH_DEF  = 64;
   localparam int HIST_DEPTH_DEF = 16;

   // Fixed field widths.
   localparam int TIME_W  = 48;
   localparam int ALT_W   = 32;
   localparam int RATE_W  = 30;
   localparam int HALF_W  = TIME_W / 2;
   localparam int LHS_W   = 53;
   localparam int PROD_W  = RATE_W + TIME_W;
   localparam int MINW_W  = 7;

   localparam logic [19:0] US_PER_S = 20'd1000000;

   // Event codes.
   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_AIR  = 2'd1;
   localparam logic [1:0] EV_LAND = 2'd2;

   // Register indexes.
   localparam logic [2:0] REG_AIR_RATE  = 3'd0;
   localparam logic [2:0] REG_LAND_RATE = 3'd1;
   localparam logic [2:0] REG_TIME_THR  = 3'd2;
   localparam logic [2:0] REG_LAND_ALT  = 3'd3;
   localparam logic [2:0] REG_AVG_PER   = 3'd4;
   localparam logic [2:0] REG_MIN_WIN   = 3'd5;

   // One window sample.
   typedef struct packed {
      logic [TIME_W-1:0]       time_us;
      logic signed [ALT_W-1:0] alt;
   } win_ent_type;

   // One stored average.
   typedef struct packed {
      logic                    valid;
      logic [TIME_W-1:0]       time_us;
      logic signed [ALT_W-1:0] alt;
   } hist_ent_type;

   // Thresholds used by the pair compare unit.
   typedef struct packed {
      logic [RATE_W-1:0]       air_rate;
      logic [RATE_W-1:0]       land_rate;
      logic [31:0]             time_thr;
      logic signed [ALT_W-1:0] land_alt;
   } cmp_cfg_type;

   // Compare unit result for one pair.
   typedef struct packed {
      logic valid;
      logic air;
      logic land;
   } cmp_res_type;

endpackage

/* src/afed_win_cell.sv */
module afed_win_cell
   import afed_pkg::*;
(
   input  logic        clock,
   input  logic        shift,
   input  win_ent_type d,
   output win_ent_type q
);

   win_ent_type ent_ff;

   // Take the neighbor's sample on each transfer.
   always_ff @(posedge clock) begin
      if (shift) begin
         ent_ff <= d;
      end
   end

   assign q = ent_ff;

endmodule

/* src/afed_hist_cell.sv */
module afed_hist_cell
   import afed_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         shift,
   input  logic         rotate,
   input  hist_ent_type prev_ent,
   input  hist_ent_type next_ent,
   output hist_ent_type q
);

   hist_ent_type ent_ff;
   hist_ent_type ent_in;

   // Insert moves entries toward the old end; a scan rotates them toward cell zero.
   always_comb begin
      ent_in = ent_ff;
      if (shift) begin
         ent_in = prev_ent;
      end else if (rotate) begin
         ent_in = next_ent;
      end
   end

   // Only the valid flag is cleared by reset.
   always_ff @(posedge clock) begin
      ent_ff.time_us <= ent_in.time_us;
      ent_ff.alt     <= ent_in.alt;
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
   end

   assign q = ent_ff;

endmodule

/* src/afed_div.sv */
module afed_div #(
   parameter int N = 38,
   parameter int M = 7
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [M-1:0] divisor,
   output logic [N-1:0] quotient,
   output logic         done
);

   localparam int CW = $clog2(N + 1);

   logic [M-1:0]  rem_ff, rem_in, dvs_ff;
   logic [N-1:0]  quo_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [M:0]    trial;
   logic [M:0]    diff;
   logic          ge;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      trial  = {rem_ff, quo_ff[N-1]};
      ge     = trial >= {1'b0, dvs_ff};
      diff   = trial - {1'b0, dvs_ff};
      rem_in = ge ? diff[M-1:0] : trial[M-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(N);
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[N-2:0], ge};
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* src/afed_cmp.sv */
module afed_cmp
   import afed_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_in,
   input  cmp_cfg_type  cfg,
   input  hist_ent_type newest,
   input  hist_ent_type older,
   output cmp_res_type  res
);

   logic [TIME_W-1:0]   dt;
   logic signed [ALT_W:0] dalt;
   logic [ALT_W:0]      da;

   logic                s1_valid_ff, s1_ok_ff, s1_alt_ok_ff;
   logic [LHS_W-1:0]    s1_lhs_ff;
   logic [RATE_W+HALF_W-1:0] s1_pa0_ff, s1_pa1_ff, s1_pl0_ff, s1_pl1_ff;
   logic [PROD_W-1:0]   prod_air, prod_land, lhs_ext;
   cmp_res_type         res_ff;

   // Stage one: time gate, altitude difference and partial rate products.
   always_comb begin
      dt   = newest.time_us - older.time_us;
      dalt = {newest.alt[ALT_W-1], newest.alt} - {older.alt[ALT_W-1], older.alt};
      da   = dalt[ALT_W] ? (ALT_W+1)'(-dalt) : dalt;
   end

   always_ff @(posedge clock) begin
      s1_ok_ff     <= (older.time_us <= newest.time_us) && (dt > TIME_W'(cfg.time_thr));
      s1_alt_ok_ff <= newest.alt < cfg.land_alt;
      s1_lhs_ff    <= LHS_W'(da * US_PER_S);
      s1_pa0_ff    <= cfg.air_rate * dt[HALF_W-1:0];
      s1_pa1_ff    <= cfg.air_rate * dt[TIME_W-1:HALF_W];
      s1_pl0_ff    <= cfg.land_rate * dt[HALF_W-1:0];
      s1_pl1_ff    <= cfg.land_rate * dt[TIME_W-1:HALF_W];
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= valid_in;
      end
   end

   // Stage two: rebuild the full products and compare the cross-multiplied rates.
   always_comb begin
      prod_air  = PROD_W'(s1_pa0_ff) + {s1_pa1_ff, {HALF_W{1'b0}}};
      prod_land = PROD_W'(s1_pl0_ff) + {s1_pl1_ff, {HALF_W{1'b0}}};
      lhs_ext   = PROD_W'(s1_lhs_ff);
   end

   always_ff @(posedge clock) begin
      res_ff.air  <= s1_ok_ff && (lhs_ext > prod_air);
      res_ff.land <= s1_ok_ff && s1_alt_ok_ff && (lhs_ext < prod_land);
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= s1_valid_ff;
      end
   end

   assign res = res_ff;

endmodule

/* src/altitude_flight_event_detector.sv */
// Altitude flight event detector.
// Samples (timestamp_us, altitude_mm) arrive on the req_ channel; a transfer
// happens when req_valid is high and req_stall is low. Each sample gives one
// result on the rsp_ channel: the event found (none, airborne, landing),
// whether the sample closed the window into a new average, and that mean.
// Registers are written on the csr_ channel (csr_ready is always high);
// write them only while the block is idle; the block does not enforce this.
// A sample that forms no average goes from its transfer to the output stage,
// and the next sample is taken once its result is in the output register.
// A sample that forms an average first runs through the bit-serial dividers
// for the mean time and altitude, is then inserted into the rotating history
// ring, which passes one stored average per cycle through the compare
// pipeline, and then reaches the output register. One sample is in work at
// a time.
// When the receiver stalls, the result stays in the output register; the
// next sample is still taken and worked on, then waits with req_stall high
// until the output register is handed on.
// Reset empties the window and the history and restores the register
// defaults; the block is ready as soon as reset falls.
module altitude_flight_event_detector
   import afed_pkg::*;
#(
   parameter int WINDOW_DEPTH  = WIN_DEPTH_DEF,
   parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [TIME_W-1:0]       req_timestamp_us,
   input  logic signed [ALT_W-1:0] req_altitude_mm,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_event_res,
   output logic                    rsp_average_formed,
   output logic signed [ALT_W-1:0] rsp_average_altitude,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_data
);

   localparam int FW  = $clog2(WINDOW_DEPTH + 1);
   localparam int ASW = ALT_W + $clog2(WINDOW_DEPTH);
   localparam int TSW = TIME_W + $clog2(WINDOW_DEPTH);
   localparam int CW  = (FW > MINW_W) ? FW : MINW_W;
   localparam int SCW = $clog2(HISTORY_DEPTH + 2);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   // Configuration registers.
   cmp_cfg_type       cfg_ff;
   logic [31:0]       avg_per_ff;
   logic [MINW_W-1:0] min_win_ff;

   logic [1:0]             state_ff, state_in;
   logic [FW-1:0]          fill_ff;
   logic signed [ASW-1:0]  alt_sum_ff;
   logic [TSW-1:0]         time_sum_ff;
   logic [SCW-1:0]         scan_cnt_ff;
   logic                   air_ff, land_ff, neg_ff;
   hist_ent_type           newest_ff;
   logic [1:0]             res_ev_ff;
   logic                   res_formed_ff;
   logic signed [ALT_W-1:0] res_alt_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_ev_ff;
   logic                   rsp_formed_ff;
   logic signed [ALT_W-1:0] rsp_alt_ff;

   logic                   req_acc, full, due, div_start, out_free;
   logic signed [ASW-1:0]  alt_sum_in;
   logic [TSW-1:0]         time_sum_in;
   logic [FW-1:0]          fill_after;
   logic [ASW-1:0]         alt_mag;
   logic [TIME_W-1:0]      since_avg;
   logic [ASW-1:0]         alt_quo, alt_mean_w;
   logic [TSW-1:0]         time_quo;
   logic                   alt_done, time_done;
   logic                   hist_shift, hist_rotate, cmp_valid, scan_end;
   logic                   air_now, land_now;
   hist_ent_type           new_avg;
   cmp_res_type            cmp_res;

   win_ent_type  win_q   [WINDOW_DEPTH];
   hist_ent_type hist_q  [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hist_valid;

   assign csr_ready = 1'b1;
   assign req_acc   = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.air_rate  <= RATE_W'(25000);
         cfg_ff.land_rate <= RATE_W'(500);
         cfg_ff.time_thr  <= 32'd2000000;
         cfg_ff.land_alt  <= 32'sd100000;
         avg_per_ff       <= 32'd500000;
         min_win_ff       <= MINW_W'(10);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_AIR_RATE:  cfg_ff.air_rate  <= csr_data[RATE_W-1:0];
            REG_LAND_RATE: cfg_ff.land_rate <= csr_data[RATE_W-1:0];
            REG_TIME_THR:  cfg_ff.time_thr  <= csr_data;
            REG_LAND_ALT:  cfg_ff.land_alt  <= csr_data;
            REG_AVG_PER:   avg_per_ff       <= csr_data;
            REG_MIN_WIN:   min_win_ff       <= csr_data[MINW_W-1:0];
            default: ;
         endcase
      end
   end

   // Window chain: new samples enter cell zero; the oldest sits in the last cell.
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_win
      win_ent_type d;
      if (i == 0) begin : g_head
         assign d = '{time_us: req_timestamp_us, alt: req_altitude_mm};
      end else begin : g_body
         assign d = win_q[i-1];
      end
      afed_win_cell u_cell (
         .clock (clock),
         .shift (req_acc),
         .d     (d),
         .q     (win_q[i])
      );
   end

   // Sample intake: due test, running sums and the fill count.
   always_comb begin
      full        = fill_ff == FW'(WINDOW_DEPTH);
      alt_sum_in  = alt_sum_ff + ASW'(req_altitude_mm)
                    - (full ? ASW'(win_q[WINDOW_DEPTH-1].alt) : '0);
      time_sum_in = time_sum_ff + TSW'(req_timestamp_us)
                    - (full ? TSW'(win_q[WINDOW_DEPTH-1].time_us) : '0);
      fill_after  = full ? fill_ff : fill_ff + FW'(1);
      alt_mag     = alt_sum_in[ASW-1] ? ASW'(-alt_sum_in) : ASW'(alt_sum_in);
      since_avg   = req_timestamp_us - hist_q[0].time_us;
      if (!hist_q[0].valid) begin
         due = 1'b1;
      end else if (req_timestamp_us >= hist_q[0].time_us
                   && since_avg > TIME_W'(avg_per_ff)) begin
         due = CW'(fill_ff) > CW'(min_win_ff);
      end else begin
         due = 1'b0;
      end
      div_start = req_acc && due;
   end

   afed_div #(.N(ASW), .M(FW)) u_div_alt (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (alt_mag),
      .divisor  (fill_after),
      .quotient (alt_quo),
      .done     (alt_done)
   );

   afed_div #(.N(TSW), .M(FW)) u_div_time (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (time_sum_in),
      .divisor  (fill_after),
      .quotient (time_quo),
      .done     (time_done)
   );

   // New average from the quotients; truncation toward zero by sign-magnitude.
   always_comb begin
      alt_mean_w      = neg_ff ? -alt_quo : alt_quo;
      new_avg.valid   = 1'b1;
      new_avg.time_us = time_quo[TIME_W-1:0];
      new_avg.alt     = alt_mean_w[ALT_W-1:0];
      hist_shift      = (state_ff == ST_DIV) && alt_done && time_done;
      hist_rotate     = (state_ff == ST_SCAN) && (scan_cnt_ff < SCW'(HISTORY_DEPTH));
      cmp_valid       = hist_rotate && (scan_cnt_ff != '0) && hist_q[0].valid;
      scan_end        = (state_ff == ST_SCAN) && (scan_cnt_ff == SCW'(HISTORY_DEPTH + 1));
      air_now         = air_ff || (cmp_res.valid && cmp_res.air);
      land_now        = land_ff || (cmp_res.valid && cmp_res.land);
      out_free        = !rsp_valid_ff || !rsp_stall;
   end

   // History ring: insert at cell zero, rotate one place per scan cycle.
   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_hist
      hist_ent_type prev_ent, next_ent;
      if (i == 0) begin : g_head
         assign prev_ent = new_avg;
      end else begin : g_body
         assign prev_ent = hist_q[i-1];
      end
      assign next_ent = hist_q[(i + 1) % HISTORY_DEPTH];
      assign hist_valid[i] = hist_q[i].valid;
      afed_hist_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (hist_shift),
         .rotate   (hist_rotate),
         .prev_ent (prev_ent),
         .next_ent (next_ent),
         .q        (hist_q[i])
      );
   end

   afed_cmp u_cmp (
      .clock    (clock),
      .reset    (reset),
      .valid_in (cmp_valid),
      .cfg      (cfg_ff),
      .newest   (newest_ff),
      .older    (hist_q[0]),
      .res      (cmp_res)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_acc) state_in = due ? ST_DIV : ST_OUT;
         ST_DIV:  if (hist_shift) state_in = ST_SCAN;
         ST_SCAN: if (scan_end) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         alt_sum_ff   <= '0;
         time_sum_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_acc) begin
            neg_ff <= alt_sum_in[ASW-1];
            if (due) begin
               fill_ff     <= '0;
               alt_sum_ff  <= '0;
               time_sum_ff <= '0;
            end else begin
               fill_ff       <= fill_after;
               alt_sum_ff    <= alt_sum_in;
               time_sum_ff   <= time_sum_in;
               res_ev_ff     <= EV_NONE;
               res_formed_ff <= 1'b0;
               res_alt_ff    <= '0;
            end
         end
         if (hist_shift) begin
            newest_ff     <= new_avg;
            res_alt_ff    <= new_avg.alt;
            res_formed_ff <= 1'b1;
            scan_cnt_ff   <= '0;
            air_ff        <= 1'b0;
            land_ff       <= 1'b0;
         end
         if (state_ff == ST_SCAN) begin
            scan_cnt_ff <= scan_cnt_ff + SCW'(1);
            air_ff      <= air_now;
            land_ff     <= land_now;
            if (scan_end) begin
               res_ev_ff <= air_now ? EV_AIR : (land_now ? EV_LAND : EV_NONE);
            end
         end
         // Output register: load a finished result, or empty after a transfer.
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff  <= 1'b1;
            rsp_ev_ff     <= res_ev_ff;
            rsp_formed_ff <= res_formed_ff;
            rsp_alt_ff    <= res_alt_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_res        = rsp_ev_ff;
   assign rsp_average_formed   = rsp_formed_ff;
   assign rsp_average_altitude = rsp_alt_ff;

   // An event is only reported together with a new average.
   a_event_needs_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_NONE |-> rsp_average_formed)
      else $error("event reported without an average");

   // Without a new average the mean field reads zero.
   a_no_avg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_average_formed |-> rsp_average_altitude == '0)
      else $error("nonzero mean without an average");

   // While the block is idle the history holds its entries packed from cell zero.
   a_hist_packed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> ((hist_valid + HISTORY_DEPTH'(1)) & hist_valid) == '0)
      else $error("history ring not packed");

   // A scan only starts after a new average was inserted.
   a_scan_after_insert: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_SCAN) |-> hist_q[0].valid && $past(hist_shift))
      else $error("scan started without an insert");

endmodule
